### design/sks_pkg.sv
package sks_pkg;

   localparam int KEY_W  = 32;
   localparam int KIND_W = 8;
   localparam int COST_W = 32;
   localparam int SKEY_W = 31;
   localparam int SCOST_W = 31;
   localparam int IDX_W  = 8;
   localparam int CNT_W  = 9;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_KIND_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KIND_MAX = 2'd1;

   localparam logic [KIND_W-1:0] KIND_MIN_RESET = 8'd0;
   localparam logic [KIND_W-1:0] KIND_MAX_RESET = 8'd3;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } sks_op_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind_min;
      logic [KIND_W-1:0] kind_max;
   } sks_cfg_type;

   typedef struct packed {
      logic [SKEY_W-1:0]  key;
      logic [KIND_W-1:0]  kind;
      logic [SCOST_W-1:0] cost;
   } sks_entry_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   index;
      logic [KIND_W-1:0]  found_kind;
      logic [SCOST_W-1:0] found_cost;
      logic               table_ok;
      logic [CNT_W-1:0]   count;
   } sks_result_type;

endpackage

### design/sorted_key_table_search.sv
// Channel  Direction  Beat
// req_     in         tuser: op; tdata: key, kind, cost
// rsp_     out        tdata: found, index, found_kind, found_cost, table_ok, count
// csr_     in         write enable, register index, write data
//
// One beat at a time. A find makes one registered read of the table memory per
// probe, up to clog2(count+1) probes.
// Reset empties the table; the memory itself is never cleared.
// A result waits in the output register while the next beat is taken.
module sorted_key_table_search
   import sks_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [71:0]            req_tdata,  // key[31:0], kind[39:32], cost[71:40]
   input  logic [1:0]             req_tuser,  // op[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,  // found[0], index[8:1], found_kind[16:9],
                                              // found_cost[47:17], table_ok[48],
                                              // count[57:49], zero[63:58]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);

   sks_cfg_type    cfg_ff;
   logic           rsp_valid_ff;
   sks_result_type rsp_ff;
   logic           out_free;
   logic           res_done;
   sks_result_type res;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   sks_entry_type  wr_data, rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind_min <= KIND_MIN_RESET;
         cfg_ff.kind_max <= KIND_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KIND_MIN: cfg_ff.kind_min <= csr_wdata;
            CSR_KIND_MAX: cfg_ff.kind_max <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   sks_engine #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (sks_op_type'(req_tuser)),
      .req_key   (req_tdata[31:0]),
      .req_kind  (req_tdata[39:32]),
      .req_cost  (req_tdata[71:40]),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .res_done  (res_done),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   sks_store #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_done && out_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.count, rsp_ff.table_ok, rsp_ff.found_cost,
                        rsp_ff.found_kind, rsp_ff.index, rsp_ff.found};

endmodule

### design/sks_store.sv
module sks_store
   import sks_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  sks_entry_type                  wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output sks_entry_type                  rd_data
);

   sks_entry_type entry_mem [TABLE_DEPTH];
   sks_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sks_engine.sv
module sks_engine
   import sks_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sks_op_type                     req_op,
   input  logic [KEY_W-1:0]               req_key,
   input  logic [KIND_W-1:0]              req_kind,
   input  logic [COST_W-1:0]              req_cost,
   input  sks_cfg_type                    cfg,
   input  logic                           out_free,
   output logic                           res_done,
   output sks_result_type                 res,
   output logic                           wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   output sks_entry_type                  wr_data,
   output logic                           rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  sks_entry_type                  rd_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPLY
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SKEY_W-1:0]  last_key_ff, last_key_in;
   logic               valid_ff, valid_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [CW-1:0]      mid_ff, mid_in;
   logic [SKEY_W-1:0]  key_ff, key_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [KIND_W-1:0]  fkind_ff, fkind_in;
   logic [SCOST_W-1:0] fcost_ff, fcost_in;

   logic          accept;
   logic          key_pos;
   logic          append_ok;
   logic [CW-1:0] up_lo, up_mid, dn_mid;
   logic          up_cont, dn_cont;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign key_pos   = !req_key[KEY_W-1] && (req_key != '0);
   assign append_ok = key_pos && (req_key[SKEY_W-1:0] > last_key_ff)
                      && (req_kind >= cfg.kind_min) && (req_kind <= cfg.kind_max)
                      && !req_cost[COST_W-1] && (count_ff < DEPTH_C);

   // both possible next probes, chosen once the stored key is back
   assign up_lo   = mid_ff + CW'(1);
   assign up_mid  = up_lo + ((hi_ff - up_lo) >> 1);
   assign up_cont = (up_lo < hi_ff);
   assign dn_mid  = lo_ff + ((mid_ff - lo_ff) >> 1);
   assign dn_cont = (lo_ff < mid_ff);

   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = '{key: req_key[SKEY_W-1:0], kind: req_kind,
                      cost: req_cost[SCOST_W-1:0]};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_key_in = last_key_ff;
      valid_in    = valid_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      key_in      = key_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      fkind_in    = fkind_ff;
      fcost_in    = fcost_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = mid_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               idx_in   = '0;
               fkind_in = '0;
               fcost_in = '0;
               key_in   = req_key[SKEY_W-1:0];
               state_in = ST_REPLY;
               case (req_op)
                  OP_CLEAR: begin
                     count_in    = '0;
                     last_key_in = '0;
                     valid_in    = 1'b1;
                  end
                  OP_APPEND: begin
                     if (valid_ff) begin
                        if (append_ok) begin
                           wr_en       = 1'b1;
                           count_in    = count_ff + CW'(1);
                           last_key_in = req_key[SKEY_W-1:0];
                        end else begin
                           valid_in = 1'b0;
                        end
                     end
                  end
                  OP_FIND: begin
                     if (valid_ff && key_pos && (count_ff != '0)) begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = count_ff >> 1;
                        rd_en    = 1'b1;
                        rd_addr  = mid_in[AW-1:0];
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (rd_data.key == key_ff) begin
               found_in = 1'b1;
               idx_in   = IDX_W'(mid_ff);
               fkind_in = rd_data.kind;
               fcost_in = rd_data.cost;
               state_in = ST_REPLY;
            end else if (rd_data.key < key_ff) begin
               lo_in  = up_lo;
               mid_in = up_mid;
               if (up_cont) begin
                  rd_en   = 1'b1;
                  rd_addr = up_mid[AW-1:0];
               end else begin
                  state_in = ST_REPLY;
               end
            end else begin
               hi_in  = mid_ff;
               mid_in = dn_mid;
               if (dn_cont) begin
                  rd_en   = 1'b1;
                  rd_addr = dn_mid[AW-1:0];
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         last_key_ff <= '0;
         valid_ff    <= 1'b1;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         last_key_ff <= last_key_in;
         valid_ff    <= valid_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      fkind_ff <= fkind_in;
      fcost_ff <= fcost_in;
   end

   assign res_done = (state_ff == ST_REPLY);
   assign res = '{found: found_ff, index: idx_ff, found_kind: fkind_ff,
                  found_cost: fcost_ff, table_ok: valid_ff, count: CNT_W'(count_ff)};

endmodule

### tb/tb_top.sv
module tb_top;
   import sks_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      sks_op_type         op;
      logic [KEY_W-1:0]   key;
      logic [KIND_W-1:0]  kind;
      logic [COST_W-1:0]  cost;
   } table_cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [71:0]            req_tdata = '0;
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the table
   logic [SKEY_W-1:0]  tbl_key  [0:TABLE_DEPTH-1];
   logic [KIND_W-1:0]  tbl_kind [0:TABLE_DEPTH-1];
   logic [SCOST_W-1:0] tbl_cost [0:TABLE_DEPTH-1];
   int unsigned        tbl_count;
   logic [SKEY_W-1:0]  tbl_last;
   logic               tbl_valid;
   logic [KIND_W-1:0]  cfg_min;
   logic [KIND_W-1:0]  cfg_max;

   table_cmd_type  pending_cmds [$];
   sks_result_type awaited_rsp [$];
   table_cmd_type  cur_cmd = '{OP_CLEAR, '0, '0, '0};
   sks_result_type want;

   int  queued = 0;
   int  beats_in = 0;
   int  results_seen = 0;
   int  hits_seen = 0;
   int  errors = 0;
   int  send_gap = 0;
   int  rsp_stall = 0;
   logic send_busy;
   logic rsp_rdy;
   logic calm = 1'b0;

   always #2 clock = ~clock;

   sorted_key_table_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic void table_reset();
      tbl_count = 0;
      tbl_last  = '0;
      tbl_valid = 1'b1;
      cfg_min   = KIND_MIN_RESET;
      cfg_max   = KIND_MAX_RESET;
   endfunction

   function automatic sks_result_type table_step(input table_cmd_type c);
      sks_result_type r;
      logic key_pos;
      int unsigned lo, hi, mid;
      r = '0;
      key_pos = (c.key != '0) && !c.key[KEY_W-1];
      case (c.op)
         OP_CLEAR: begin
            tbl_count = 0;
            tbl_last  = '0;
            tbl_valid = 1'b1;
         end
         OP_APPEND: begin
            if (tbl_valid) begin
               if (key_pos && c.key[SKEY_W-1:0] > tbl_last && c.kind >= cfg_min &&
                   c.kind <= cfg_max && !c.cost[COST_W-1] && tbl_count < TABLE_DEPTH) begin
                  tbl_key[tbl_count]  = c.key[SKEY_W-1:0];
                  tbl_kind[tbl_count] = c.kind;
                  tbl_cost[tbl_count] = c.cost[SCOST_W-1:0];
                  tbl_count++;
                  tbl_last = c.key[SKEY_W-1:0];
               end else begin
                  tbl_valid = 1'b0;
               end
            end
         end
         OP_FIND: begin
            if (tbl_valid && key_pos) begin
               lo = 0;
               hi = tbl_count;
               while (lo < hi && !r.found) begin
                  mid = lo + (hi - lo) / 2;
                  if (tbl_key[mid] == c.key[SKEY_W-1:0]) begin
                     r.found      = 1'b1;
                     r.index      = mid[IDX_W-1:0];
                     r.found_kind = tbl_kind[mid];
                     r.found_cost = tbl_cost[mid];
                  end else if (tbl_key[mid] < c.key[SKEY_W-1:0]) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid;
                  end
               end
            end
         end
         default: ;
      endcase
      r.table_ok = tbl_valid;
      r.count    = tbl_count[CNT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want_v, got_v);
      if (want_v !== got_v) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         send_busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            awaited_rsp.push_back(table_step(cur_cmd));
            beats_in++;
            send_busy = 1'b0;
         end
         if (!send_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 5);
            end else if (pending_cmds.size() > 0) begin
               cur_cmd = pending_cmds.pop_front();
               send_busy = 1'b1;
            end
         end
         req_tvalid <= send_busy;
         req_tdata  <= {cur_cmd.cost, cur_cmd.kind, cur_cmd.key};
         req_tuser  <= cur_cmd.op;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_rsp.size() == 0) begin
               $display("%0t unexpected result beat: expected none, actual %0h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("found", 64'(want.found), 64'(rsp_tdata[0]));
               check_field("index", 64'(want.index), 64'(rsp_tdata[8:1]));
               check_field("found_kind", 64'(want.found_kind), 64'(rsp_tdata[16:9]));
               check_field("found_cost", 64'(want.found_cost), 64'(rsp_tdata[47:17]));
               check_field("table_ok", 64'(want.table_ok), 64'(rsp_tdata[48]));
               check_field("count", 64'(want.count), 64'(rsp_tdata[57:49]));
               check_field("padding", 64'd0, 64'(rsp_tdata[63:58]));
               if (want.found) hits_seen++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_rdy = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 5);
            rsp_rdy = 1'b0;
         end else begin
            rsp_rdy = 1'b1;
         end
         rsp_tready <= rsp_rdy;
      end
   end

   task automatic push(input sks_op_type op, input logic [KEY_W-1:0] key,
                       input logic [KIND_W-1:0] kind, input logic [COST_W-1:0] cost);
      pending_cmds.push_back('{op, key, kind, cost});
      queued++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_KIND_MIN) cfg_min = val;
      else if (idx == CSR_KIND_MAX) cfg_max = val;
   endtask

   task automatic wait_idle();
      while (results_seen != queued) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // clear, then build a table of up to n records with finds mixed in; 1 in bad_odds appends broken
   task automatic table_run(input int n, input int bad_odds);
      longint unsigned last, k, span;
      logic [KEY_W-1:0]  gk [$];
      logic [KIND_W-1:0] kd;
      logic [COST_W-1:0] cs;
      int nf;
      span = (n > 64) ? 64'd65536 : (64'd1 << (2 + 7 * $urandom_range(0, 4)));
      last = $urandom % span;
      push(OP_CLEAR, $urandom, 8'($urandom), $urandom);
      for (int i = 0; i < n; i++) begin
         k = last + 1 + ($urandom % span);
         if (k > 64'h7FFF_FFFF) break;
         kd = (cfg_min <= cfg_max) ? 8'($urandom_range(cfg_max, cfg_min)) : 8'($urandom);
         cs = $urandom & 32'h7FFF_FFFF;
         if (bad_odds > 0 && $urandom_range(1, bad_odds) == 1) begin
            case ($urandom_range(0, 4))
               0: push(OP_APPEND, (gk.size() > 0) ? gk[$] : 32'd0, kd, cs);
               1: push(OP_APPEND, 32'd0, kd, cs);
               2: push(OP_APPEND, 32'h8000_0000 | $urandom, kd, cs);
               3: begin
                  if (cfg_min > 0)
                     push(OP_APPEND, k[31:0], 8'($urandom_range(0, cfg_min - 1)), cs);
                  else if (cfg_max < 8'hFF)
                     push(OP_APPEND, k[31:0], 8'($urandom_range(cfg_max + 1, 255)), cs);
                  else
                     push(OP_APPEND, k[31:0], kd, cs | 32'h8000_0000);
               end
               default: push(OP_APPEND, k[31:0], kd, 32'h8000_0000 | $urandom);
            endcase
         end else begin
            push(OP_APPEND, k[31:0], kd, cs);
            gk.push_back(k[31:0]);
            last = k;
         end
         if (gk.size() > 0 && $urandom_range(0, 5) == 0)
            push(OP_FIND, gk[$urandom_range(0, gk.size() - 1)], 8'($urandom), $urandom);
      end
      nf = n / 2 + $urandom_range(2, 6);
      repeat (nf) begin
         case ($urandom_range(0, 9))
            0, 1: push(OP_FIND, $urandom, 8'($urandom), $urandom);
            2, 3: begin
               if (gk.size() > 0)
                  push(OP_FIND, gk[$urandom_range(0, gk.size() - 1)] +
                       (($urandom_range(0, 1) == 1) ? 32'd1 : 32'hFFFF_FFFF),
                       8'($urandom), $urandom);
               else
                  push(OP_FIND, $urandom_range(1, 8), 8'($urandom), $urandom);
            end
            default: begin
               if (gk.size() > 0)
                  push(OP_FIND, gk[$urandom_range(0, gk.size() - 1)], 8'($urandom),
                       $urandom);
               else
                  push(OP_FIND, $urandom, 8'($urandom), $urandom);
            end
         endcase
         if ($urandom_range(0, 19) == 0) push(OP_NONE, $urandom, 8'($urandom), $urandom);
      end
   endtask

   initial begin
      #(4 * 500000);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [7:0] lo_k, hi_k;
      table_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset bounds 0..3
      push(OP_CLEAR, 32'd0, 8'd0, 32'd0);
      push(OP_FIND, 32'd1, 8'd0, 32'd0);
      push(OP_APPEND, 32'd1, 8'd0, 32'd0);
      push(OP_APPEND, 32'd5, 8'd3, 32'h7FFF_FFFF);
      push(OP_FIND, 32'd1, 8'hFF, 32'hFFFF_FFFF);
      push(OP_FIND, 32'd5, 8'd0, 32'd0);
      push(OP_FIND, 32'd3, 8'd0, 32'd0);
      push(OP_FIND, 32'd0, 8'd0, 32'd0);
      push(OP_FIND, 32'h8000_0000, 8'd0, 32'd0);
      push(OP_FIND, 32'hFFFF_FFFF, 8'd0, 32'd0);
      push(OP_NONE, 32'd5, 8'hFF, 32'hFFFF_FFFF);
      push(OP_APPEND, 32'd5, 8'd1, 32'd1);           // repeated key
      push(OP_FIND, 32'd1, 8'd0, 32'd0);
      push(OP_APPEND, 32'd9, 8'd0, 32'd0);           // table invalid, ignored
      push(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      push(OP_APPEND, 32'd2, 8'd4, 32'd0);           // kind above max
      push(OP_CLEAR, 32'd0, 8'd0, 32'd0);
      push(OP_APPEND, 32'd2, 8'd0, 32'h8000_0000);   // negative cost
      push(OP_CLEAR, 32'd0, 8'd0, 32'd0);
      push(OP_APPEND, 32'd0, 8'd0, 32'd0);           // zero key
      push(OP_CLEAR, 32'd0, 8'd0, 32'd0);
      push(OP_APPEND, 32'hFFFF_FFFF, 8'd0, 32'd0);   // negative key
      push(OP_CLEAR, 32'd0, 8'd0, 32'd0);
      push(OP_APPEND, 32'h7FFF_FFFF, 8'd2, 32'd1);
      push(OP_FIND, 32'h7FFF_FFFF, 8'd0, 32'd0);
      wait_idle();

      write_reg(CSR_KIND_MIN, 8'd0);
      write_reg(CSR_KIND_MAX, 8'hFF);
      write_reg(CSR_SPARE_A, 8'($urandom));
      write_reg(CSR_SPARE_B, 8'($urandom));
      repeat (6) table_run($urandom_range(0, 12), 8);
      wait_idle();

      // fill to depth, then one append too many
      table_run(TABLE_DEPTH + 1, 0);
      wait_idle();

      write_reg(CSR_KIND_MIN, 8'hFF);
      write_reg(CSR_KIND_MAX, 8'd0);
      repeat (2) table_run(4, 0);
      wait_idle();

      write_reg(CSR_KIND_MAX, 8'hFF);
      repeat (3) table_run($urandom_range(1, 10), 8);
      wait_idle();

      while (queued < 1200) begin
         if (queued > 1050) calm = 1'b1;
         lo_k = 8'($urandom_range(0, 80));
         hi_k = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, lo_k))
                                             : 8'($urandom_range(lo_k, 255));
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_KIND_MIN, lo_k);
            write_reg(CSR_KIND_MAX, hi_k);
         end else begin
            write_reg(CSR_KIND_MAX, hi_k);
            write_reg(CSR_KIND_MIN, lo_k);
         end
         repeat ($urandom_range(2, 6))
            table_run(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12), 8);
         wait_idle();
      end

      $display("%0d request beats, %0d results checked, %0d find hits", beats_in,
               results_seen, hits_seen);
      $display("covered a full table, inverted and extreme kind bounds, bad appends, op 3");
      if (errors == 0 && awaited_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
